[sv/crc16fr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the CRC-16 frame receiver.
package crc16fr_pkg;

  localparam logic [7:0]  START_BYTE   = 8'hA5;
  localparam logic [7:0]  TRAILER_BYTE = 8'h5A;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_CRC_ERROR   = 2'd1;
  localparam logic [1:0] STATUS_BAD_TRAILER = 2'd2;

  typedef enum logic [7:0] {
    PH_HUNT    = 8'b0000_0001,
    PH_LEN_LO  = 8'b0000_0010,
    PH_LEN_HI  = 8'b0000_0100,
    PH_TYPE    = 8'b0000_1000,
    PH_PAYLOAD = 8'b0001_0000,
    PH_CRC_LO  = 8'b0010_0000,
    PH_CRC_HI  = 8'b0100_0000,
    PH_TRAILER = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0]  frame_type;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [15:0] frame_len;
    logic        last;
    logic [1:0]  status;
  } result_t;

endpackage

[sv/crc16fr_if.sv]
`timescale 1ns / 1ps
// Handshake interfaces for the received byte stream and the result stream.
interface crc16fr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface crc16fr_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_type;
  logic [7:0]  data_byte;
  logic [15:0] byte_index;
  logic [15:0] frame_len;
  logic        last;
  logic [1:0]  status;

  modport source (output valid, output frame_type, output data_byte, output byte_index,
                  output frame_len, output last, output status, input ready);
  modport sink (input valid, input frame_type, input data_byte, input byte_index,
                input frame_len, input last, input status, output ready);
endinterface

[sv/crc16_frame_receiver.sv]
`timescale 1ns / 1ps
// A received byte is registered on acceptance; its result is registered in the result register
// when the parser takes the byte, which waits while a payload or trailer result cannot be stored.
// Throughput: one byte per cycle while results drain, set by the byte-wide CRC update and phase step.
// The result register lets a new header or CRC byte be taken while an earlier result is still waiting.
// Reset (synchronous, active high) returns the parser to hunting for the start byte and
// empties both registers; no clearing pass is needed.
module crc16_frame_receiver (
  input  logic                     clk,
  input  logic                     rst,
  crc16fr_byte_if.sink             rx,
  crc16fr_result_if.source         frame
);

  logic                 byte_valid;
  logic [7:0]           byte_hold;
  logic                 take;
  logic                 emit;
  logic                 out_free;
  logic                 out_valid;
  crc16fr_pkg::result_t result;
  crc16fr_pkg::result_t out_hold;

  assign out_free = !out_valid || frame.ready;
  assign rx.ready = !byte_valid || take;

  crc16fr_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_in    (byte_hold),
    .out_free   (out_free),
    .take       (take),
    .emit       (emit),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      byte_valid <= 1'b1;
    end else if (take) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      byte_hold <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (frame.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_hold <= result;
    end
  end

  assign frame.valid      = out_valid;
  assign frame.frame_type = out_hold.frame_type;
  assign frame.data_byte  = out_hold.data_byte;
  assign frame.byte_index = out_hold.byte_index;
  assign frame.frame_len  = out_hold.frame_len;
  assign frame.last       = out_hold.last;
  assign frame.status     = out_hold.status;

endmodule

[sv/crc16fr_crc_byte.sv]
`timescale 1ns / 1ps
// Byte-wide update of the reflected CRC-16 with polynomial 0xA001.
module crc16fr_crc_byte (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ crc16fr_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

[sv/crc16fr_parser.sv]
`timescale 1ns / 1ps
// Frame parser: phase sequencer, length and CRC tracking and result formation.
module crc16fr_parser (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     byte_valid,
  input  logic [7:0]               byte_in,
  input  logic                     out_free,
  output logic                     take,
  output logic                     emit,
  output crc16fr_pkg::result_t     result
);

  crc16fr_pkg::phase_t phase, phase_next;
  logic [15:0] expected_len, expected_len_next;
  logic [7:0]  type_hold, type_hold_next;
  logic [15:0] payload_count, payload_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] received_crc, received_crc_next;
  logic [15:0] crc_fed;
  logic [15:0] count_inc;
  logic        has_result;

  crc16fr_crc_byte u_crc (
    .crc_in  (running_crc),
    .data    (byte_in),
    .crc_out (crc_fed)
  );

  assign count_inc  = payload_count + 16'd1;
  assign has_result = (phase == crc16fr_pkg::PH_PAYLOAD) || (phase == crc16fr_pkg::PH_TRAILER);
  assign take       = byte_valid && (!has_result || out_free);
  assign emit       = take && has_result;

  always_comb begin
    result.frame_type = type_hold;
    result.frame_len  = expected_len;
    result.byte_index = payload_count;
    if (phase == crc16fr_pkg::PH_TRAILER) begin
      result.data_byte = 8'h00;
      result.last      = 1'b1;
      if (byte_in != crc16fr_pkg::TRAILER_BYTE) begin
        result.status = crc16fr_pkg::STATUS_BAD_TRAILER;
      end else if (received_crc != running_crc) begin
        result.status = crc16fr_pkg::STATUS_CRC_ERROR;
      end else begin
        result.status = crc16fr_pkg::STATUS_OK;
      end
    end else begin
      result.data_byte = byte_in;
      result.last      = 1'b0;
      result.status    = crc16fr_pkg::STATUS_OK;
    end
  end

  always_comb begin
    phase_next         = phase;
    expected_len_next  = expected_len;
    type_hold_next     = type_hold;
    payload_count_next = payload_count;
    running_crc_next   = running_crc;
    received_crc_next  = received_crc;
    if (take) begin
      unique case (phase)
        crc16fr_pkg::PH_HUNT: begin
          if (byte_in == crc16fr_pkg::START_BYTE) begin
            phase_next         = crc16fr_pkg::PH_LEN_LO;
            payload_count_next = 16'd0;
            running_crc_next   = crc16fr_pkg::CRC_INIT;
          end
        end
        crc16fr_pkg::PH_LEN_LO: begin
          expected_len_next = {8'h00, byte_in};
          phase_next        = crc16fr_pkg::PH_LEN_HI;
        end
        crc16fr_pkg::PH_LEN_HI: begin
          expected_len_next = {byte_in, expected_len[7:0]};
          phase_next        = crc16fr_pkg::PH_TYPE;
        end
        crc16fr_pkg::PH_TYPE: begin
          type_hold_next   = byte_in;
          running_crc_next = crc_fed;
          phase_next       = (expected_len == 16'd0) ? crc16fr_pkg::PH_CRC_LO
                                                     : crc16fr_pkg::PH_PAYLOAD;
        end
        crc16fr_pkg::PH_PAYLOAD: begin
          running_crc_next   = crc_fed;
          payload_count_next = count_inc;
          if (count_inc == expected_len) begin
            phase_next = crc16fr_pkg::PH_CRC_LO;
          end
        end
        crc16fr_pkg::PH_CRC_LO: begin
          received_crc_next = {8'h00, byte_in};
          phase_next        = crc16fr_pkg::PH_CRC_HI;
        end
        crc16fr_pkg::PH_CRC_HI: begin
          received_crc_next = {byte_in, received_crc[7:0]};
          phase_next        = crc16fr_pkg::PH_TRAILER;
        end
        crc16fr_pkg::PH_TRAILER: begin
          phase_next = crc16fr_pkg::PH_HUNT;
        end
        default: begin
          phase_next = crc16fr_pkg::PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= crc16fr_pkg::PH_HUNT;
      expected_len  <= 16'd0;
      type_hold     <= 8'h00;
      payload_count <= 16'd0;
      running_crc   <= crc16fr_pkg::CRC_INIT;
      received_crc  <= 16'd0;
    end else begin
      phase         <= phase_next;
      expected_len  <= expected_len_next;
      type_hold     <= type_hold_next;
      payload_count <= payload_count_next;
      running_crc   <= running_crc_next;
      received_crc  <= received_crc_next;
    end
  end

  // A result is only formed when the output register can take it.
  assert property (@(posedge clk) disable iff (rst) emit |-> out_free)
    else $error("result formed while the output register is full");

  // While payload is streaming, the count never reaches the announced length.
  assert property (@(posedge clk) disable iff (rst)
    (phase == crc16fr_pkg::PH_PAYLOAD) |-> (payload_count < expected_len))
    else $error("payload count has run past the frame length");

  // The trailer byte always ends the frame and the parser returns to hunting.
  assert property (@(posedge clk) disable iff (rst)
    (take && (phase == crc16fr_pkg::PH_TRAILER)) |=> (phase == crc16fr_pkg::PH_HUNT))
    else $error("parser did not return to hunting after the trailer");

  // A payload result never carries the end mark.
  assert property (@(posedge clk) disable iff (rst)
    (emit && (phase == crc16fr_pkg::PH_PAYLOAD)) |-> (!result.last))
    else $error("payload result marked as end of frame");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the CRC-16 frame receiver, with scoreboard and stimulus tasks.
module testbench;
  import crc16fr_pkg::*;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_CRC,
    FRAME_BAD_TRAILER,
    FRAME_BAD_BOTH,
    FRAME_LONG_LEN
  } frame_kind_e;

  class frame_scoreboard;
    phase_t      phase;
    logic [15:0] announced_len;
    logic [7:0]  held_type;
    logic [15:0] payload_seen;
    logic [15:0] crc_acc;
    logic [15:0] crc_rx;
    result_t     expected_q[$];
    int          errors;
    int          results_seen;
    int          frames_ok;
    int          frames_failed;

    function new();
      phase         = PH_HUNT;
      announced_len = '0;
      held_type     = '0;
      payload_seen  = '0;
      crc_acc       = CRC_INIT;
      crc_rx        = '0;
      errors        = 0;
      results_seen  = 0;
      frames_ok     = 0;
      frames_failed = 0;
    endfunction

    static function logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
        if (c[0]) c = (c >> 1) ^ CRC_POLY;
        else c = c >> 1;
      end
      return c;
    endfunction

    function bit is_hunting();
      return phase == PH_HUNT;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_byte(logic [7:0] b);
      result_t r;
      r.frame_type = held_type;
      r.data_byte  = 8'h00;
      r.byte_index = payload_seen;
      r.frame_len  = announced_len;
      r.last       = 1'b0;
      r.status     = STATUS_OK;
      case (phase)
        PH_HUNT: begin
          if (b == START_BYTE) begin
            phase        = PH_LEN_LO;
            payload_seen = '0;
            crc_acc      = CRC_INIT;
          end
        end
        PH_LEN_LO: begin
          announced_len = {8'h00, b};
          phase         = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          announced_len[15:8] = b;
          phase               = PH_TYPE;
        end
        PH_TYPE: begin
          held_type = b;
          crc_acc   = crc16_update(crc_acc, b);
          phase     = (announced_len == 16'd0) ? PH_CRC_LO : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          crc_acc     = crc16_update(crc_acc, b);
          r.data_byte = b;
          expected_q.push_back(r);
          payload_seen = payload_seen + 16'd1;
          if (payload_seen == announced_len) phase = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          crc_rx = {8'h00, b};
          phase  = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          crc_rx[15:8] = b;
          phase        = PH_TRAILER;
        end
        default: begin
          r.last = 1'b1;
          if (b != TRAILER_BYTE) r.status = STATUS_BAD_TRAILER;
          else if (crc_rx != crc_acc) r.status = STATUS_CRC_ERROR;
          else r.status = STATUS_OK;
          expected_q.push_back(r);
          phase = PH_HUNT;
        end
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("Result with no request waiting: data_byte 0x%0h last %0b",
               got.data_byte, got.last);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("frame_type", {8'h00, want.frame_type}, {8'h00, got.frame_type});
      compare_field("data_byte", {8'h00, want.data_byte}, {8'h00, got.data_byte});
      compare_field("byte_index", want.byte_index, got.byte_index);
      compare_field("frame_len", want.frame_len, got.frame_len);
      compare_field("last", {15'h0, want.last}, {15'h0, got.last});
      compare_field("status", {14'h0, want.status}, {14'h0, got.status});
      if (want.last) begin
        if (want.status == STATUS_OK) frames_ok++;
        else frames_failed++;
      end
    endfunction

    function void check_leftovers();
      if (expected_q.size() != 0) begin
        $error("%0d expected results never arrived", expected_q.size());
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  crc16fr_byte_if   rx_if ();
  crc16fr_result_if res_if ();

  crc16_frame_receiver dut (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx_if),
    .frame (res_if)
  );

  frame_scoreboard sb = new();

  int      send_idle_pct = 37;
  int      recv_idle_pct = 49;
  bit      stall_request = 1'b0;
  int      stall_left    = 0;
  int      frame_items   = 0;
  int      frames_sent   = 0;
  result_t seen_result;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_left    = 300;
        stall_request = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      seen_result.frame_type = res_if.frame_type;
      seen_result.data_byte  = res_if.data_byte;
      seen_result.byte_index = res_if.byte_index;
      seen_result.frame_len  = res_if.frame_len;
      seen_result.last       = res_if.last;
      seen_result.status     = res_if.status;
      sb.check_result(seen_result);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    if (!sb.is_hunting() || b == START_BYTE) frame_items++;
    sb.note_byte(b);
  endtask

  task automatic send_noise(input int count);
    logic [7:0] b;
    repeat (count) begin
      do b = 8'($urandom); while (b == START_BYTE);
      send_byte(b);
    end
  endtask

  task automatic send_frame(input logic [7:0] ftype, input int len, input frame_kind_e kind);
    logic [15:0] crc;
    logic [15:0] declared;
    logic [7:0]  b;
    crc      = CRC_INIT;
    declared = (kind == FRAME_LONG_LEN) ? 16'(len + int'($urandom_range(3, 1))) : 16'(len);
    frames_sent++;
    send_byte(START_BYTE);
    send_byte(declared[7:0]);
    send_byte(declared[15:8]);
    send_byte(ftype);
    crc = frame_scoreboard::crc16_update(crc, ftype);
    for (int i = 0; i < len; i++) begin
      b = ($urandom_range(9) == 0) ? START_BYTE : 8'($urandom);
      send_byte(b);
      crc = frame_scoreboard::crc16_update(crc, b);
    end
    if (kind == FRAME_BAD_CRC || kind == FRAME_BAD_BOTH) crc = crc ^ (16'h1 << $urandom_range(15));
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
    if (kind == FRAME_BAD_TRAILER || kind == FRAME_BAD_BOTH) begin
      do b = 8'($urandom); while (b == TRAILER_BYTE);
    end else begin
      b = TRAILER_BYTE;
    end
    send_byte(b);
    while (!sb.is_hunting()) send_byte(8'h00);
  endtask

  task automatic send_random_frame();
    int          r;
    int          len;
    frame_kind_e kind;
    r = $urandom_range(99);
    if (r < 4) len = 0;
    else if (r < 89) len = $urandom_range(12, 1);
    else if (r < 97) len = $urandom_range(64, 13);
    else if (r < 99) len = 165;
    else len = $urandom_range(300, 256);
    r = $urandom_range(99);
    if (r < 70) kind = FRAME_GOOD;
    else if (r < 80) kind = FRAME_BAD_CRC;
    else if (r < 88) kind = FRAME_BAD_TRAILER;
    else if (r < 93) kind = FRAME_BAD_BOTH;
    else kind = FRAME_LONG_LEN;
    send_frame(8'($urandom), len, kind);
  endtask

  task automatic wait_for_results(input int spare);
    int waited;
    waited = 0;
    rx_if.valid <= 1'b0;
    while (sb.pending() > 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (spare) @(posedge clk);
  endtask

  initial begin
    int stage;
    stage = 0;
    rst           <= 1'b1;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'h00, 0, FRAME_GOOD);
    send_frame(8'hFF, 1, FRAME_GOOD);
    send_frame(START_BYTE, 0, FRAME_BAD_BOTH);

    while (frame_items < 1500) begin
      if (stage == 0 && frame_items >= 500) begin
        wait_for_results(4);
        send_idle_pct = 49;
        recv_idle_pct = 37;
        stall_request = 1'b1;
        send_frame(8'h3C, 40, FRAME_GOOD);
        stage = 1;
      end else if (stage == 1 && frame_items >= 1000) begin
        wait_for_results(4);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stage = 2;
      end
      send_noise($urandom_range(3));
      send_random_frame();
    end

    wait_for_results(20);
    sb.check_leftovers();
    $display("Sent %0d frames in %0d frame bytes; %0d results checked.",
             frames_sent, frame_items, sb.results_seen);
    $display("Frame ends seen: %0d good, %0d reporting an error.", sb.frames_ok, sb.frames_failed);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[sim.f]
sv/crc16fr_pkg.sv
sv/crc16fr_if.sv
sv/crc16fr_crc_byte.sv
sv/crc16fr_parser.sv
sv/crc16_frame_receiver.sv
dv/testbench.sv
